FILE: rtl/core/krsp_pkg.sv
// Package with the transaction types and fixed codes of the keyboard report sequence player.
`timescale 1ns / 1ps

package krsp_pkg;

    localparam int ENTRY_W     = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [2:0] FUNC_TICK   = 3'd0;
    localparam logic [2:0] FUNC_APPEND = 3'd1;
    localparam logic [2:0] FUNC_CLEAR  = 3'd2;
    localparam logic [2:0] FUNC_START  = 3'd3;
    localparam logic [2:0] FUNC_STOP   = 3'd4;
    localparam logic [2:0] FUNC_RESET  = 3'd5;
    localparam logic [2:0] FUNC_INIT   = 3'd6;

    localparam logic [1:0] STATUS_IDLE     = 2'd0;
    localparam logic [1:0] STATUS_WAITING  = 2'd1;
    localparam logic [1:0] STATUS_RUNNING  = 2'd2;
    localparam logic [1:0] STATUS_COMPLETE = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_AUTO_TRIGGER    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIGGER_DELAY   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_UPDATE_INTERVAL = 2'd2;

    localparam logic [15:0] UPDATE_INTERVAL_RESET = 16'd10;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  modifier_bits;
        logic [7:0]  key_code;
        logic [15:0] pad_count;
        logic        host_ready;
        logic        link_up;
        logic        host_attached;
    } item_t;

    typedef struct packed {
        logic        report_valid;
        logic [7:0]  report_modifier;
        logic [7:0]  report_key;
        logic [1:0]  status;
        logic        running;
        logic        accepted;
        logic [9:0]  table_length;
        logic        trigger_done;
    } result_t;

endpackage

FILE: rtl/core/keyboard_report_sequence_player_unit.sv
// Top level of the keyboard report sequence player: entry table, playback and auto-trigger.
//
//   Channel   Signals                                  Direction
//   item      item_valid, item_stall, item             command transaction in
//   result    result_valid, result_stall, result       one result transaction per command
//   cfg       cfg_valid, cfg_ready, cfg_index, cfg_data register write
//
// Most commands have their result registered at acceptance.
// A tick that emits a report passes through S_READ, since the entry table has a registered read.
// An append writes the key entry at acceptance, then the release and empty entries after it in S_APPEND.
// No clearing pass follows reset; the table is only read below its fill count.
// A stalled result holds the block off new commands until it is taken.
`timescale 1ns / 1ps

module keyboard_report_sequence_player_unit
    import krsp_pkg::*;
#(
    parameter int TABLE_DEPTH = 512
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 17;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_APPEND = 3'b010,
        S_READ   = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  pidx_reg, pidx_next;
    logic [CNT_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]        status_reg, status_next;
    logic              playing_reg, playing_next;
    logic              fired_reg, fired_next;
    logic              cd_active_reg, cd_active_next;
    logic [31:0]       cd_reg, cd_next;
    logic [15:0]       since_reg, since_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg, out_data_next;

    logic              auto_en_reg;
    logic [31:0]       trig_delay_reg;
    logic [15:0]       interval_reg;

    logic [ENTRY_W-1:0] entry_mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;

    logic accept;
    logic acc;
    logic emit;

    assign item_stall   = (state_reg != S_IDLE) || (out_valid_reg && result_stall);
    assign accept       = item_valid && !item_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;
    assign cfg_ready    = 1'b1;

    always_comb
    begin
        logic [15:0]      since_v;
        logic [31:0]      cd_v;
        logic [SUM_W-1:0] sum_v;

        state_next     = state_reg;
        count_next     = count_reg;
        pidx_next      = pidx_reg;
        wr_ptr_next    = wr_ptr_reg;
        status_next    = status_reg;
        playing_next   = playing_reg;
        fired_next     = fired_reg;
        cd_active_next = cd_active_reg;
        cd_next        = cd_reg;
        since_next     = since_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[ADDR_W-1:0];
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = pidx_reg[ADDR_W-1:0];
        acc            = 1'b0;
        emit           = 1'b0;
        since_v        = since_reg;
        cd_v           = cd_reg;
        sum_v          = SUM_W'(count_reg) + SUM_W'(item.pad_count) + SUM_W'(2);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (item.func)
                        FUNC_TICK:
                        begin
                            if (since_reg != 16'hFFFF)
                            begin
                                since_v = since_reg + 16'd1;
                            end
                            if (cd_active_reg && (cd_reg != 32'hFFFF_FFFF))
                            begin
                                cd_v = cd_reg + 32'd1;
                            end
                            if (auto_en_reg && !fired_reg)
                            begin
                                if (!item.link_up || !item.host_attached)
                                begin
                                    cd_active_next = 1'b0;
                                    cd_v           = '0;
                                    status_next    = STATUS_WAITING;
                                end
                                else if (!cd_active_reg && (status_reg == STATUS_WAITING))
                                begin
                                    cd_active_next = 1'b1;
                                    cd_v           = '0;
                                end
                                else if (cd_active_reg && (cd_v >= trig_delay_reg))
                                begin
                                    if (!playing_reg && (count_reg != '0))
                                    begin
                                        playing_next = 1'b1;
                                        pidx_next    = '0;
                                        since_v      = '0;
                                    end
                                    fired_next  = 1'b1;
                                    status_next = STATUS_RUNNING;
                                end
                            end
                            if (playing_next && item.host_ready && (since_v >= interval_reg))
                            begin
                                since_v = '0;
                                if (pidx_next >= count_reg)
                                begin
                                    playing_next = 1'b0;
                                    status_next  = STATUS_COMPLETE;
                                end
                                else
                                begin
                                    emit      = 1'b1;
                                    mem_re    = 1'b1;
                                    mem_raddr = pidx_next[ADDR_W-1:0];
                                    pidx_next = pidx_next + CNT_W'(1);
                                end
                            end
                            since_next = since_v;
                            cd_next    = cd_v;
                        end
                        FUNC_APPEND:
                        begin
                            if (count_reg < CNT_W'(TABLE_DEPTH - 2))
                            begin
                                acc         = 1'b1;
                                mem_we      = 1'b1;
                                mem_waddr   = count_reg[ADDR_W-1:0];
                                mem_wdata   = {item.modifier_bits, item.key_code};
                                wr_ptr_next = count_reg + CNT_W'(1);
                                count_next  = (sum_v >= SUM_W'(TABLE_DEPTH)) ?
                                              CNT_W'(TABLE_DEPTH) : sum_v[CNT_W-1:0];
                                state_next  = S_APPEND;
                            end
                        end
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                            pidx_next  = '0;
                        end
                        FUNC_START:
                        begin
                            if (!playing_reg && (count_reg != '0))
                            begin
                                acc          = 1'b1;
                                playing_next = 1'b1;
                                status_next  = STATUS_RUNNING;
                                pidx_next    = '0;
                                since_next   = '0;
                            end
                        end
                        FUNC_STOP:
                        begin
                            if (playing_reg)
                            begin
                                playing_next = 1'b0;
                                status_next  = STATUS_IDLE;
                            end
                        end
                        FUNC_RESET:
                        begin
                            playing_next   = 1'b0;
                            status_next    = STATUS_IDLE;
                            pidx_next      = '0;
                            fired_next     = 1'b0;
                            cd_active_next = 1'b0;
                            cd_next        = '0;
                        end
                        FUNC_INIT:
                        begin
                            count_next     = '0;
                            pidx_next      = '0;
                            status_next    = auto_en_reg ? STATUS_WAITING : STATUS_IDLE;
                            playing_next   = 1'b0;
                            fired_next     = 1'b0;
                            cd_active_next = 1'b0;
                            cd_next        = '0;
                            since_next     = '0;
                        end
                        default:
                        begin
                        end
                    endcase

                    if (emit)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        out_valid_next                = 1'b1;
                        out_data_next.report_valid    = 1'b0;
                        out_data_next.report_modifier = '0;
                        out_data_next.report_key      = '0;
                        out_data_next.status          = status_next;
                        out_data_next.running         = playing_next;
                        out_data_next.accepted        = acc;
                        out_data_next.table_length    = 10'(count_next);
                        out_data_next.trigger_done    = fired_next;
                    end
                end
            end
            S_APPEND:
            begin
                mem_we      = 1'b1;
                mem_waddr   = wr_ptr_reg[ADDR_W-1:0];
                mem_wdata   = '0;
                wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                if (wr_ptr_next == count_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                out_valid_next                = 1'b1;
                out_data_next.report_valid    = 1'b1;
                out_data_next.report_modifier = rdata_reg[15:8];
                out_data_next.report_key      = rdata_reg[7:0];
                out_data_next.status          = status_reg;
                out_data_next.running         = playing_reg;
                out_data_next.accepted        = 1'b0;
                out_data_next.table_length    = 10'(count_reg);
                out_data_next.trigger_done    = fired_reg;
                state_next                    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= entry_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pidx_reg      <= '0;
            wr_ptr_reg    <= '0;
            status_reg    <= STATUS_IDLE;
            playing_reg   <= 1'b0;
            fired_reg     <= 1'b0;
            cd_active_reg <= 1'b0;
            cd_reg        <= '0;
            since_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pidx_reg      <= pidx_next;
            wr_ptr_reg    <= wr_ptr_next;
            status_reg    <= status_next;
            playing_reg   <= playing_next;
            fired_reg     <= fired_next;
            cd_active_reg <= cd_active_next;
            cd_reg        <= cd_next;
            since_reg     <= since_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_en_reg    <= 1'b0;
            trig_delay_reg <= '0;
            interval_reg   <= UPDATE_INTERVAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_AUTO_TRIGGER:    auto_en_reg    <= cfg_data[0];
                CFG_TRIGGER_DELAY:   trig_delay_reg <= cfg_data;
                CFG_UPDATE_INTERVAL: interval_reg   <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("Entry count exceeds the table depth.");

    a_append_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPEND) |-> (wr_ptr_reg < count_reg))
        else $error("Append write pointer passed the entry count.");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPEND) |=> $stable(count_reg))
        else $error("Entry count changed during an append.");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> result_valid)
        else $error("Emitted report did not reach the result register.");

    a_complete_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (status_reg == STATUS_COMPLETE) |-> !playing_reg)
        else $error("Playback still runs with status complete.");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the keyboard report sequence player, with a predictor and random phases.
`timescale 1ns / 1ps

module testbench
    import krsp_pkg::*;
();

    localparam int          DEPTH       = 512;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          PHASES      = 8;
    localparam int          PHASE_ITEMS = 50;
    localparam logic [2:0]  FUNC_UNUSED = 3'd7;

    typedef struct {
        bit          new_settings;
        bit          set_auto;
        logic [31:0] set_delay;
        logic [15:0] set_interval;
        item_t       cmd;
        bit          typed;
        result_t     want;
    } directed_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_stall;
    item_t                  item;
    logic                   result_valid;
    logic                   result_stall;
    result_t                result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predicted player state and register copies.
    logic [15:0] entries [DEPTH];
    int unsigned fill_count;
    int unsigned play_pos;
    logic [1:0]  mode;
    bit          playing;
    bit          fired;
    bit          countdown_on;
    logic [31:0] countdown_ms;
    logic [15:0] since_report_ms;
    bit          auto_en;
    logic [31:0] trigger_delay;
    logic [15:0] update_interval;

    result_t       expected_results[$];
    directed_row_t directed_rows[$];
    int unsigned   mismatch_count;
    int unsigned   cycle_count;
    int unsigned   commands_sent;
    int unsigned   reports_seen;
    int unsigned   appends_taken;
    bit            calm;

    keyboard_report_sequence_player_unit #(
        .TABLE_DEPTH(DEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item        (item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic item_t make_cmd(logic [2:0] f, logic [7:0] m, logic [7:0] k,
                                       logic [15:0] d, bit rdy, bit lnk, bit usb);
        item_t c;
        c.func          = f;
        c.modifier_bits = m;
        c.key_code      = k;
        c.pad_count     = d;
        c.host_ready    = rdy;
        c.link_up       = lnk;
        c.host_attached = usb;
        return c;
    endfunction

    function automatic result_t make_result(bit v, logic [7:0] m, logic [7:0] k, logic [1:0] st,
                                            bit run, bit acc, logic [9:0] len, bit done);
        result_t r;
        r.report_valid    = v;
        r.report_modifier = m;
        r.report_key      = k;
        r.status          = st;
        r.running         = run;
        r.accepted        = acc;
        r.table_length    = len;
        r.trigger_done    = done;
        return r;
    endfunction

    function automatic bit begin_play();
        if (playing || fill_count == 0)
            return 1'b0;
        playing         = 1'b1;
        mode            = STATUS_RUNNING;
        play_pos        = 0;
        since_report_ms = '0;
        return 1'b1;
    endfunction

    function automatic void clear_player();
        fill_count      = 0;
        play_pos        = 0;
        mode            = STATUS_IDLE;
        playing         = 1'b0;
        fired           = 1'b0;
        countdown_on    = 1'b0;
        countdown_ms    = '0;
        since_report_ms = '0;
    endfunction

    function automatic result_t predict_player_step(item_t c);
        result_t     r;
        logic [15:0] e;
        r = '0;
        case (c.func)
            FUNC_TICK:
            begin
                if (since_report_ms != 16'hFFFF)
                    since_report_ms++;
                if (countdown_on && countdown_ms != 32'hFFFF_FFFF)
                    countdown_ms++;
                if (auto_en && !fired)
                begin
                    if (!c.link_up || !c.host_attached)
                    begin
                        countdown_on = 1'b0;
                        countdown_ms = '0;
                        mode         = STATUS_WAITING;
                    end
                    else if (!countdown_on && mode == STATUS_WAITING)
                    begin
                        countdown_on = 1'b1;
                        countdown_ms = '0;
                    end
                    else if (countdown_on && countdown_ms >= trigger_delay)
                    begin
                        void'(begin_play());
                        fired = 1'b1;
                        mode  = STATUS_RUNNING;
                    end
                end
                if (playing && c.host_ready && since_report_ms >= update_interval)
                begin
                    since_report_ms = '0;
                    if (play_pos >= fill_count)
                    begin
                        playing = 1'b0;
                        mode    = STATUS_COMPLETE;
                    end
                    else
                    begin
                        e                 = entries[play_pos % DEPTH];
                        play_pos++;
                        r.report_valid    = 1'b1;
                        r.report_modifier = e[15:8];
                        r.report_key      = e[7:0];
                    end
                end
            end
            FUNC_APPEND:
            begin
                if (fill_count < DEPTH - 2)
                begin
                    entries[fill_count] = {c.modifier_bits, c.key_code};
                    fill_count++;
                    entries[fill_count] = '0;
                    fill_count++;
                    for (int i = 0; i < c.pad_count && fill_count < DEPTH; i++)
                    begin
                        entries[fill_count] = '0;
                        fill_count++;
                    end
                    r.accepted = 1'b1;
                end
            end
            FUNC_CLEAR:
            begin
                foreach (entries[i])
                    entries[i] = '0;
                fill_count = 0;
                play_pos   = 0;
            end
            FUNC_START:
                r.accepted = begin_play();
            FUNC_STOP:
            begin
                if (playing)
                begin
                    playing = 1'b0;
                    mode    = STATUS_IDLE;
                end
            end
            FUNC_RESET:
            begin
                playing      = 1'b0;
                mode         = STATUS_IDLE;
                play_pos     = 0;
                fired        = 1'b0;
                countdown_on = 1'b0;
                countdown_ms = '0;
            end
            FUNC_INIT:
            begin
                clear_player();
                if (auto_en)
                    mode = STATUS_WAITING;
            end
            default:
            begin
            end
        endcase
        r.status       = mode;
        r.running      = playing;
        r.table_length = fill_count[9:0];
        r.trigger_done = fired;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic compare_result(result_t got, result_t want);
        if (got.report_valid !== want.report_valid)
            report_mismatch("report_valid", got.report_valid, want.report_valid);
        if (got.report_modifier !== want.report_modifier)
            report_mismatch("report_modifier", got.report_modifier, want.report_modifier);
        if (got.report_key !== want.report_key)
            report_mismatch("report_key", got.report_key, want.report_key);
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.running !== want.running)
            report_mismatch("running", got.running, want.running);
        if (got.accepted !== want.accepted)
            report_mismatch("accepted", got.accepted, want.accepted);
        if (got.table_length !== want.table_length)
            report_mismatch("table_length", got.table_length, want.table_length);
        if (got.trigger_done !== want.trigger_done)
            report_mismatch("trigger_done", got.trigger_done, want.trigger_done);
    endtask

    task automatic send_command(item_t c, bit typed, result_t want);
        int unsigned gap;
        result_t     pred;
        gap = calm ? 0 : $urandom_range(0, 16);
        @(negedge clk);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= c;
        item_valid <= 1'b1;
        pred = predict_player_step(c);
        expected_results.push_back(typed ? want : pred);
        do
            @(posedge clk);
        while (item_stall);
        commands_sent++;
        if (pred.accepted && c.func == FUNC_APPEND)
            appends_taken++;
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(bit en, logic [31:0] dly, logic [15:0] ivl);
        wait_until_drained();
        write_reg(CFG_AUTO_TRIGGER, {31'd0, en});
        write_reg(CFG_TRIGGER_DELAY, dly);
        write_reg(CFG_UPDATE_INTERVAL, {16'd0, ivl});
        auto_en         = en;
        trigger_delay   = dly;
        update_interval = ivl;
    endtask

    function automatic item_t random_command();
        item_t       c;
        int unsigned pick;
        pick            = $urandom_range(0, 99);
        c.func          = pick < 52 ? FUNC_TICK :
                          pick < 72 ? FUNC_APPEND :
                          pick < 79 ? FUNC_START :
                          pick < 83 ? FUNC_STOP :
                          pick < 87 ? FUNC_CLEAR :
                          pick < 91 ? FUNC_RESET :
                          pick < 96 ? FUNC_INIT : FUNC_UNUSED;
        c.modifier_bits = 8'($urandom_range(0, 255));
        c.key_code      = 8'($urandom_range(0, 255));
        c.pad_count     = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 65535))
                                                        : 16'($urandom_range(0, 6));
        c.host_ready    = $urandom_range(0, 9) < 8;
        c.link_up       = $urandom_range(0, 9) < 9;
        c.host_attached = $urandom_range(0, 9) < 9;
        return c;
    endfunction

    function automatic void add_row(bit ns, bit en, logic [31:0] dly, logic [15:0] ivl,
                                    item_t c, bit typed, result_t want);
        directed_row_t row;
        row.new_settings = ns;
        row.set_auto     = en;
        row.set_delay    = dly;
        row.set_interval = ivl;
        row.cmd          = c;
        row.typed        = typed;
        row.want         = want;
        directed_rows.push_back(row);
    endfunction

    function automatic void build_directed_rows();
        result_t none;
        none = '0;
        // Zero interval, auto-trigger off.
        add_row(1, 0, 0, 0, make_cmd(FUNC_TICK, 0, 0, 0, 1, 0, 0), 1,
                make_result(0, 0, 0, STATUS_IDLE, 0, 0, 0, 0));
        add_row(0, 0, 0, 0, make_cmd(FUNC_START, 0, 0, 0, 1, 0, 0), 1,
                make_result(0, 0, 0, STATUS_IDLE, 0, 0, 0, 0));
        add_row(0, 0, 0, 0, make_cmd(FUNC_STOP, 0, 0, 0, 1, 0, 0), 1,
                make_result(0, 0, 0, STATUS_IDLE, 0, 0, 0, 0));
        add_row(0, 0, 0, 0, make_cmd(FUNC_APPEND, 8'hFF, 8'hFF, 0, 1, 1, 1), 1,
                make_result(0, 0, 0, STATUS_IDLE, 0, 1, 2, 0));
        add_row(0, 0, 0, 0, make_cmd(FUNC_APPEND, 0, 0, 3, 0, 1, 1), 1,
                make_result(0, 0, 0, STATUS_IDLE, 0, 1, 7, 0));
        add_row(0, 0, 0, 0, make_cmd(FUNC_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 1, 1, 1), 1,
                make_result(0, 0, 0, STATUS_IDLE, 0, 0, 7, 0));
        add_row(0, 0, 0, 0, make_cmd(FUNC_START, 0, 0, 0, 1, 0, 0), 1,
                make_result(0, 0, 0, STATUS_RUNNING, 1, 1, 7, 0));
        add_row(0, 0, 0, 0, make_cmd(FUNC_TICK, 0, 0, 0, 0, 0, 0), 0, none);
        add_row(0, 0, 0, 0, make_cmd(FUNC_TICK, 0, 0, 0, 1, 0, 0), 0, none);
        add_row(0, 0, 0, 0, make_cmd(FUNC_STOP, 0, 0, 0, 1, 0, 0), 1,
                make_result(0, 0, 0, STATUS_IDLE, 0, 0, 7, 0));
        add_row(0, 0, 0, 0, make_cmd(FUNC_START, 0, 0, 0, 1, 0, 0), 1,
                make_result(0, 0, 0, STATUS_RUNNING, 1, 1, 7, 0));
        // A clear during playback ends it as complete at the next tick that finds a report due.
        add_row(0, 0, 0, 0, make_cmd(FUNC_CLEAR, 0, 0, 0, 1, 0, 0), 1,
                make_result(0, 0, 0, STATUS_RUNNING, 1, 0, 0, 0));
        add_row(0, 0, 0, 0, make_cmd(FUNC_TICK, 0, 0, 0, 1, 0, 0), 1,
                make_result(0, 0, 0, STATUS_COMPLETE, 0, 0, 0, 0));
        add_row(0, 0, 0, 0, make_cmd(FUNC_APPEND, 8'hA5, 8'h5A, 16'hFFFF, 1, 0, 0), 1,
                make_result(0, 0, 0, STATUS_COMPLETE, 0, 1, 10'd512, 0));
        add_row(0, 0, 0, 0, make_cmd(FUNC_APPEND, 8'h3C, 8'hC3, 0, 1, 0, 0), 1,
                make_result(0, 0, 0, STATUS_COMPLETE, 0, 0, 10'd512, 0));
        add_row(0, 0, 0, 0, make_cmd(FUNC_INIT, 0, 0, 0, 1, 0, 0), 1,
                make_result(0, 0, 0, STATUS_IDLE, 0, 0, 0, 0));
        add_row(0, 0, 0, 0, make_cmd(FUNC_APPEND, 8'h5A, 8'hA5, 16'h0100, 1, 0, 0), 0, none);
        add_row(0, 0, 0, 0, make_cmd(FUNC_RESET, 0, 0, 0, 1, 0, 0), 1,
                make_result(0, 0, 0, STATUS_IDLE, 0, 0, 10'd258, 0));
        // After a reset command the countdown waits for a condition to drop first.
        add_row(1, 1, 2, 0, make_cmd(FUNC_TICK, 0, 0, 0, 1, 1, 1), 1,
                make_result(0, 0, 0, STATUS_IDLE, 0, 0, 10'd258, 0));
        add_row(0, 0, 0, 0, make_cmd(FUNC_TICK, 0, 0, 0, 1, 0, 1), 1,
                make_result(0, 0, 0, STATUS_WAITING, 0, 0, 10'd258, 0));
        add_row(0, 0, 0, 0, make_cmd(FUNC_TICK, 0, 0, 0, 1, 1, 1), 0, none);
        add_row(0, 0, 0, 0, make_cmd(FUNC_TICK, 0, 0, 0, 1, 1, 1), 0, none);
        add_row(0, 0, 0, 0, make_cmd(FUNC_TICK, 0, 0, 0, 1, 1, 1), 0, none);
        add_row(0, 0, 0, 0, make_cmd(FUNC_INIT, 0, 0, 0, 1, 1, 1), 1,
                make_result(0, 0, 0, STATUS_WAITING, 0, 0, 0, 0));
        add_row(0, 0, 0, 0, make_cmd(FUNC_TICK, 0, 0, 0, 1, 1, 1), 0, none);
        add_row(0, 0, 0, 0, make_cmd(FUNC_TICK, 0, 0, 0, 1, 1, 1), 0, none);
        // The auto start fails on an empty table but still reads as running.
        add_row(0, 0, 0, 0, make_cmd(FUNC_TICK, 0, 0, 0, 1, 1, 1), 1,
                make_result(0, 0, 0, STATUS_RUNNING, 0, 0, 0, 1));
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     expected_results.size());
            $display("status: fail");
            $finish;
        end
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", result, 0);
            else
                compare_result(result, expected_results.pop_front());
            if (result.report_valid === 1'b1)
                reports_seen++;
        end
    end

    initial
    begin
        int unsigned hold;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 16);
            if (hold > 0)
            begin
                @(negedge clk);
                result_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                result_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(result_valid && !result_stall));
        end
    end

    initial
    begin
        int unsigned counted;
        item_t       c;
        logic [31:0] dly;
        logic [15:0] ivl;
        bit          en;
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        calm           = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        commands_sent  = 0;
        reports_seen   = 0;
        appends_taken  = 0;
        foreach (entries[i])
            entries[i] = '0;
        clear_player();
        auto_en         = 1'b0;
        trigger_delay   = '0;
        update_interval = UPDATE_INTERVAL_RESET;
        build_directed_rows();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].new_settings)
                apply_settings(directed_rows[i].set_auto, directed_rows[i].set_delay,
                               directed_rows[i].set_interval);
            send_command(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: begin en = 1'b1; dly = 32'hFFFF_FFFF; ivl = 16'd1; end
                1: begin en = 1'b0; dly = 32'd0; ivl = 16'hFFFF; end
                2: begin en = 1'b1; dly = 32'd0; ivl = 16'd0; end
                default:
                begin
                    en = 1'($urandom_range(0, 1));
                    case ($urandom_range(0, 5))
                        0:       dly = 32'd0;
                        1:       dly = 32'hFFFF_FFFF;
                        2:       dly = $urandom;
                        default: dly = $urandom_range(1, 8);
                    endcase
                    case ($urandom_range(0, 5))
                        0:       ivl = 16'd0;
                        1:       ivl = UPDATE_INTERVAL_RESET;
                        2:       ivl = 16'($urandom_range(0, 65535));
                        default: ivl = 16'($urandom_range(1, 4));
                    endcase
                end
            endcase
            apply_settings(en, dly, ivl);
            calm    = (phase % 3 == 2);
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                c = random_command();
                send_command(c, 1'b0, '0);
                if (c.func != FUNC_UNUSED)
                    counted++;
            end
        end

        calm = 1'b0;
        wait_until_drained();
        repeat (20) @(posedge clk);
        $display("run covered %0d commands over %0d register settings", commands_sent,
                 PHASES + 2);
        $display("%0d reports played back, %0d appends taken, %0d mismatches", reports_seen,
                 appends_taken, mismatch_count);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
